@@ sv/wdcm_pkg.sv @@
// Package for the wind direction circular mean block.
// Holds sizes, fixed-point constants, the CORDIC arctangent table and the
// controller state, command and status types. Depends on nothing.
package wdcm_pkg;

  localparam int RING_DEPTH   = 512;
  localparam int ADDR_W       = $clog2(RING_DEPTH);
  localparam int CNT_W        = $clog2(RING_DEPTH + 1);
  localparam int SORT_DEPTH   = 2 * (2 ** ADDR_W);

  localparam int WIN_W        = 10;
  localparam int ANG_W        = 12;
  localparam int DEG_W        = 9;
  localparam int HELD_W       = 10;
  localparam int Q15_W        = 16;
  localparam int SUM_W        = 26;
  localparam int KEY_W        = 25;
  localparam int XY_W         = 48;
  localparam int Z_W          = 32;
  localparam int REM_W        = 10;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);

  localparam int DEG_Q16       = 65536;
  localparam int DEG_HALF_TURN = 180;
  localparam int DEG_TURN      = 360;
  localparam int DEG_MAX       = 359;
  localparam int FULL_TURN_Q16 = DEG_TURN * DEG_Q16;
  localparam int HALF_TURN_Q16 = DEG_HALF_TURN * DEG_Q16;
  localparam int HALF_DEG_Q16  = DEG_Q16 / 2;

  localparam int TENTHS_TURN   = 3600;
  localparam int TENTHS_QUAD   = 900;

  // Gain-compensated start vector in Q2.30.
  localparam int X_START      = 652032874;
  localparam int VEC_SHIFT    = 20;
  localparam int Q15_ROUND    = 16384;
  localparam int Q15_SHIFT    = 15;
  localparam int Q15_MAX      = 32767;
  localparam int Q15_MIN      = -32768;

  // floor(n / 10) = (n * RECIP_10) >> RECIP_SHIFT for n below 2^26.
  localparam int RECIP_10     = 53687092;
  localparam int RECIP_SHIFT  = 29;
  localparam int Z_ROUND      = 5;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60);

  function automatic logic signed [Z_W-1:0] arc_q16(input logic [ITER_W-1:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      4'd0:    a = Z_W'(2949120);
      4'd1:    a = Z_W'(1740967);
      4'd2:    a = Z_W'(919879);
      4'd3:    a = Z_W'(466945);
      4'd4:    a = Z_W'(234379);
      4'd5:    a = Z_W'(117304);
      4'd6:    a = Z_W'(58666);
      4'd7:    a = Z_W'(29335);
      4'd8:    a = Z_W'(14668);
      4'd9:    a = Z_W'(7334);
      4'd10:   a = Z_W'(3667);
      4'd11:   a = Z_W'(1833);
      4'd12:   a = Z_W'(917);
      4'd13:   a = Z_W'(458);
      4'd14:   a = Z_W'(229);
      default: a = Z_W'(115);
    endcase
    return a;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROT,
    ST_SINCOS,
    ST_KEY_LD,
    ST_KEY,
    ST_STORE,
    ST_MWAIT,
    ST_MSTEP,
    ST_WRAP,
    ST_SPREAD,
    ST_MEAN_LD,
    ST_MEAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic rot_ld;
    logic cor_step;
    logic sincos;
    logic key_ld;
    logic store;
    logic merge_step;
    logic wrap;
    logic spread;
    logic mean_ld;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic item_ok;
    logic cor_last;
    logic merge_done;
    logic merge_adv;
    logic res_busy;
  } status_t;

  typedef struct packed {
    logic signed [Q15_W-1:0] sine;
    logic signed [Q15_W-1:0] cosine;
    logic [KEY_W-1:0]        key;
  } ring_entry_t;

endpackage

@@ sv/wdcm_if.sv @@
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on wdcm_pkg for field widths.
interface wdcm_in_if import wdcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ANG_W-1:0] angle_tenths;
  logic             sample_ok;

  modport source (output valid, output angle_tenths, output sample_ok, input ready);
  modport sink   (input valid, input angle_tenths, input sample_ok, output ready);
endinterface

interface wdcm_out_if import wdcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DEG_W-1:0]  mean_deg;
  logic [DEG_W-1:0]  spread_deg;
  logic [HELD_W-1:0] samples_held;

  modport source (output valid, output mean_deg, output spread_deg, output samples_held,
                  input ready);
  modport sink   (input valid, input mean_deg, input spread_deg, input samples_held,
                  output ready);
endinterface

@@ sv/wdcm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained, no package needed.
module wdcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/wdcm_cordic.sv @@
// Shared iterative CORDIC unit: rotation for sine/cosine, vectoring for atan2.
// One micro-rotation per step; depends on wdcm_pkg.
module wdcm_cordic import wdcm_pkg::*; (
  input  logic                    clk,
  input  logic                    rot_ld,
  input  logic                    vec_ld,
  input  logic                    step,
  input  logic signed [Z_W-1:0]   z_init,
  input  logic signed [SUM_W-1:0] vec_y,
  input  logic signed [SUM_W-1:0] vec_x,
  output logic                    last,
  output logic signed [Q15_W-1:0] rot_sin,
  output logic signed [Q15_W-1:0] rot_cos,
  output logic [KEY_W-1:0]        vec_angle
);

  logic signed [XY_W-1:0] x, y, x_next, y_next;
  logic signed [Z_W-1:0]  z, z_next;
  logic [ITER_W-1:0]      iter;
  logic                   mode_rot;
  logic                   flip;
  logic                   zero_in;
  logic signed [XY_W-1:0] xe, ye;

  assign xe = XY_W'(vec_x) <<< VEC_SHIFT;
  assign ye = XY_W'(vec_y) <<< VEC_SHIFT;

  always_comb begin
    logic signed [XY_W-1:0] xs, ys;
    logic                   dir;
    xs  = x >>> iter;
    ys  = y >>> iter;
    dir = mode_rot ? !z[Z_W-1] : y[XY_W-1];
    if (dir) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - arc_q16(iter);
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + arc_q16(iter);
    end
  end

  always_ff @(posedge clk) begin
    if (rot_ld) begin
      x        <= XY_W'(X_START);
      y        <= '0;
      z        <= z_init;
      iter     <= '0;
      mode_rot <= 1'b1;
    end else if (vec_ld) begin
      // A vector in the left half-plane is turned by half a turn first.
      x        <= vec_x[SUM_W-1] ? -xe : xe;
      y        <= vec_x[SUM_W-1] ? -ye : ye;
      flip     <= vec_x[SUM_W-1];
      zero_in  <= (vec_x == '0) && (vec_y == '0);
      z        <= '0;
      iter     <= '0;
      mode_rot <= 1'b0;
    end else if (step) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      iter <= iter + 1'b1;
    end
  end

  assign last = (iter == ITER_W'(CORDIC_STEPS - 1));

  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    t = (v + XY_W'(Q15_ROUND)) >>> Q15_SHIFT;
    if (t > XY_W'(Q15_MAX)) begin
      return Q15_W'(Q15_MAX);
    end else if (t < XY_W'(Q15_MIN)) begin
      return Q15_W'(Q15_MIN);
    end
    return t[Q15_W-1:0];
  endfunction

  assign rot_sin = to_q15(y);
  assign rot_cos = to_q15(x);

  always_comb begin
    logic signed [Z_W-1:0] a;
    a = (flip ? Z_W'(HALF_TURN_Q16) : Z_W'(0)) + z;
    if (a < 0) begin
      a = a + Z_W'(FULL_TURN_Q16);
    end else if (a >= Z_W'(FULL_TURN_Q16)) begin
      a = a - Z_W'(FULL_TURN_Q16);
    end
    vec_angle = zero_in ? '0 : a[KEY_W-1:0];
  end

endmodule

@@ sv/wdcm_datapath.sv @@
// Datapath: sample ring, running sums, sorted-angle merge pass, spread and
// mean rounding, result register. Depends on wdcm_pkg, wdcm_ram, wdcm_cordic.
module wdcm_datapath import wdcm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic              cfg_we,
  input  logic [WIN_W-1:0]  cfg_wdata,
  input  logic [ANG_W-1:0]  in_angle,
  input  logic              in_ok,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DEG_W-1:0]  out_mean,
  output logic [DEG_W-1:0]  out_spread,
  output logic [HELD_W-1:0] out_held
);

  logic [WIN_W-1:0]        window;
  logic signed [SUM_W-1:0] sine_sum, cosine_sum;
  logic [ADDR_W-1:0]       write_slot;
  logic [CNT_W-1:0]        fill_count;
  logic                    bank;
  logic [DEG_W-1:0]        spread;
  logic                    res_valid;

  logic [ANG_W-1:0]        item_angle;
  logic                    item_ok;
  logic [1:0]              quad;
  logic signed [Q15_W-1:0] new_s, new_c;
  logic [KEY_W-1:0]        del_key, ins_key, first_key, prev_key, max_gap;
  logic                    del_pend, ins_pend;
  logic [CNT_W-1:0]        n_old, rp, wp;

  logic [CNT_W-1:0]        win_eff;
  logic [ADDR_W-1:0]       old_slot;
  logic                    evict;
  ring_entry_t             ring_rd, ring_wr;
  logic [KEY_W-1:0]        head;

  logic signed [Z_W-1:0]   z0;
  logic [1:0]              quad_in;
  logic signed [Q15_W-1:0] sc_s, sc_c;
  logic                    cor_last;
  logic signed [Q15_W-1:0] rot_sin, rot_cos;
  logic [KEY_W-1:0]        vec_angle;
  logic signed [SUM_W-1:0] vec_y, vec_x;

  logic do_del, do_ins, do_copy, head_ok;
  logic [KEY_W-1:0]        emit;

  // Window in use, clamped to one through the ring depth.
  always_comb begin
    if (window == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window) > RING_DEPTH) begin
      win_eff = CNT_W'(RING_DEPTH);
    end else begin
      win_eff = CNT_W'(window);
    end
  end

  always_comb begin
    logic [CNT_W:0] o;
    if ((CNT_W + 1)'(write_slot) >= (CNT_W + 1)'(win_eff)) begin
      o = (CNT_W + 1)'(write_slot) - (CNT_W + 1)'(win_eff);
    end else begin
      o = (CNT_W + 1)'(write_slot) + (CNT_W + 1)'(RING_DEPTH) - (CNT_W + 1)'(win_eff);
    end
    old_slot = o[ADDR_W-1:0];
  end

  assign evict = (fill_count >= win_eff);

  // Angle reduction: quadrant, remainder, and the start angle in Q16 degrees.
  always_comb begin
    logic [ANG_W-1:0]       t;
    logic [ANG_W-1:0]       r;
    logic [REM_W+15:0]      num;
    logic [2*(REM_W+16)-1:0] prod;
    t = (item_angle >= ANG_W'(TENTHS_TURN)) ? item_angle - ANG_W'(TENTHS_TURN) : item_angle;
    if (t >= ANG_W'(3 * TENTHS_QUAD)) begin
      quad_in = 2'd3;
      r       = t - ANG_W'(3 * TENTHS_QUAD);
    end else if (t >= ANG_W'(2 * TENTHS_QUAD)) begin
      quad_in = 2'd2;
      r       = t - ANG_W'(2 * TENTHS_QUAD);
    end else if (t >= ANG_W'(TENTHS_QUAD)) begin
      quad_in = 2'd1;
      r       = t - ANG_W'(TENTHS_QUAD);
    end else begin
      quad_in = 2'd0;
      r       = t;
    end
    num  = {r[REM_W-1:0], 16'(Z_ROUND)};
    prod = (2 * (REM_W + 16))'(num) * (2 * (REM_W + 16))'(RECIP_10);
    z0   = Z_W'(prod >> RECIP_SHIFT);
  end

  always_comb begin
    case (quad)
      2'd0: begin
        sc_s = rot_sin;
        sc_c = rot_cos;
      end
      2'd1: begin
        sc_s = rot_cos;
        sc_c = -rot_sin;
      end
      2'd2: begin
        sc_s = -rot_sin;
        sc_c = -rot_cos;
      end
      default: begin
        sc_s = -rot_cos;
        sc_c = rot_sin;
      end
    endcase
  end

  assign vec_y = cmd.key_ld ? SUM_W'(new_s) : sine_sum;
  assign vec_x = cmd.key_ld ? SUM_W'(new_c) : cosine_sum;

  wdcm_cordic u_cordic (
    .clk       (clk),
    .rot_ld    (cmd.rot_ld),
    .vec_ld    (cmd.key_ld | cmd.mean_ld),
    .step      (cmd.cor_step),
    .z_init    (z0),
    .vec_y     (vec_y),
    .vec_x     (vec_x),
    .last      (cor_last),
    .rot_sin   (rot_sin),
    .rot_cos   (rot_cos),
    .vec_angle (vec_angle)
  );

  assign ring_wr = '{sine: new_s, cosine: new_c, key: vec_angle};

  wdcm_ram #(
    .WIDTH ($bits(ring_entry_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (write_slot),
    .wdata (ring_wr),
    .raddr (old_slot),
    .rdata (ring_rd)
  );

  // Merge pass: old sorted list minus the evicted angle plus the new one.
  assign head_ok = (rp < n_old);
  assign do_del  = del_pend && head_ok && (head == del_key);
  assign do_ins  = !do_del && ins_pend && (!head_ok || (ins_key <= head));
  assign do_copy = !do_del && !do_ins && head_ok;
  assign emit    = do_ins ? ins_key : head;

  wdcm_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SORT_DEPTH)
  ) u_sorted (
    .clk   (clk),
    .we    (cmd.merge_step && (do_ins || do_copy)),
    .waddr ({~bank, wp[ADDR_W-1:0]}),
    .wdata (emit),
    .raddr ({bank, rp[ADDR_W-1:0]}),
    .rdata (head)
  );

  logic [KEY_W:0]   wrap_gap;
  logic [DEG_W-1:0] spread_new;
  logic [DEG_W-1:0] mean_new;

  assign wrap_gap = (KEY_W + 1)'(FULL_TURN_Q16) - {1'b0, prev_key} + {1'b0, first_key};

  always_comb begin
    logic [KEY_W:0] sv;
    logic [KEY_W:0] rr;
    sv = (KEY_W + 1)'(FULL_TURN_Q16) - {1'b0, max_gap};
    if (max_gap == '0) begin
      sv = (KEY_W + 1)'(DEG_MAX * DEG_Q16);
    end
    rr = (sv + (KEY_W + 1)'(HALF_DEG_Q16)) >> 16;
    if (fill_count < CNT_W'(2)) begin
      spread_new = '0;
    end else if (rr > (KEY_W + 1)'(DEG_MAX)) begin
      spread_new = DEG_W'(DEG_MAX);
    end else begin
      spread_new = rr[DEG_W-1:0];
    end
  end

  always_comb begin
    logic [KEY_W:0] mr;
    mr = ({1'b0, vec_angle} + (KEY_W + 1)'(HALF_DEG_Q16)) >> 16;
    if (fill_count == '0 || mr >= (KEY_W + 1)'(DEG_TURN)) begin
      mean_new = '0;
    end else begin
      mean_new = mr[DEG_W-1:0];
    end
  end

  // Store state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= WINDOW_RESET;
      sine_sum   <= '0;
      cosine_sum <= '0;
      write_slot <= '0;
      fill_count <= '0;
      bank       <= 1'b0;
      spread     <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        window     <= cfg_wdata;
        sine_sum   <= '0;
        cosine_sum <= '0;
        write_slot <= '0;
        fill_count <= '0;
        spread     <= '0;
      end else begin
        if (cmd.sincos) begin
          sine_sum   <= sine_sum + SUM_W'(sc_s) - (evict ? SUM_W'(ring_rd.sine) : SUM_W'(0));
          cosine_sum <= cosine_sum + SUM_W'(sc_c)
                        - (evict ? SUM_W'(ring_rd.cosine) : SUM_W'(0));
          if (!evict) begin
            fill_count <= fill_count + 1'b1;
          end
        end
        if (cmd.store) begin
          write_slot <= (32'(write_slot) == RING_DEPTH - 1) ? '0 : write_slot + 1'b1;
        end
        if (cmd.spread) begin
          spread <= spread_new;
          bank   <= ~bank;
        end
      end
      if (cmd.res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_angle <= in_angle;
      item_ok    <= in_ok;
    end
    if (cmd.rot_ld) begin
      quad <= quad_in;
    end
    if (cmd.sincos) begin
      new_s    <= sc_s;
      new_c    <= sc_c;
      del_key  <= ring_rd.key;
      del_pend <= evict;
      n_old    <= fill_count;
    end
    if (cmd.store) begin
      ins_key  <= vec_angle;
      ins_pend <= 1'b1;
      rp       <= '0;
      wp       <= '0;
      max_gap  <= '0;
    end
    if (cmd.merge_step) begin
      if (do_del) begin
        del_pend <= 1'b0;
        rp       <= rp + 1'b1;
      end else if (do_ins || do_copy) begin
        if (do_ins) begin
          ins_pend <= 1'b0;
        end else begin
          rp <= rp + 1'b1;
        end
        if (wp == '0) begin
          first_key <= emit;
        end else if (emit - prev_key > max_gap) begin
          max_gap <= emit - prev_key;
        end
        prev_key <= emit;
        wp       <= wp + 1'b1;
      end
    end
    if (cmd.wrap && (wrap_gap > {1'b0, max_gap})) begin
      max_gap <= wrap_gap[KEY_W-1:0];
    end
    if (cmd.res_load) begin
      out_mean   <= mean_new;
      out_spread <= spread;
      out_held   <= HELD_W'(fill_count);
    end
  end

  assign out_valid     = res_valid;
  assign st.item_ok    = item_ok;
  assign st.cor_last   = cor_last;
  assign st.merge_done = !do_del && !do_ins && !do_copy;
  assign st.merge_adv  = do_del || do_copy;
  assign st.res_busy   = res_valid && !out_ready;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= RING_DEPTH)
    else $error("fill count beyond ring depth");

  a_merge_len: assert property (@(posedge clk) disable iff (rst)
    cmd.spread |-> (wp == fill_count))
    else $error("merge pass length differs from samples held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!res_valid || out_ready))
    else $error("result register overwritten before it was taken");
`endif

endmodule

@@ sv/wdcm_ctrl.sv @@
// Controller state machine: sequences CORDIC runs, ring update, merge pass
// and result hand-off. Depends on wdcm_pkg.
module wdcm_ctrl import wdcm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_PREP;
      ST_PREP:    state_next = st.item_ok ? ST_ROT : ST_MEAN;
      ST_ROT:     if (st.cor_last) state_next = ST_SINCOS;
      ST_SINCOS:  state_next = ST_KEY_LD;
      ST_KEY_LD:  state_next = ST_KEY;
      ST_KEY:     if (st.cor_last) state_next = ST_STORE;
      ST_STORE:   state_next = ST_MWAIT;
      ST_MWAIT:   state_next = ST_MSTEP;
      ST_MSTEP: begin
        if (st.merge_done) begin
          state_next = ST_WRAP;
        end else if (st.merge_adv) begin
          state_next = ST_MWAIT;
        end
      end
      ST_WRAP:    state_next = ST_SPREAD;
      ST_SPREAD:  state_next = ST_MEAN_LD;
      ST_MEAN_LD: state_next = ST_MEAN;
      ST_MEAN:    if (st.cor_last) state_next = ST_DONE;
      ST_DONE:    if (!st.res_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_PREP: begin
        // A failed read leaves the store alone; only the mean is redone.
        cmd.rot_ld  = st.item_ok;
        cmd.mean_ld = !st.item_ok;
      end
      ST_ROT, ST_KEY, ST_MEAN: cmd.cor_step = 1'b1;
      ST_SINCOS:  cmd.sincos     = 1'b1;
      ST_KEY_LD:  cmd.key_ld     = 1'b1;
      ST_STORE:   cmd.store      = 1'b1;
      ST_MWAIT:   cmd.merge_step = 1'b0;
      ST_MSTEP:   cmd.merge_step = 1'b1;
      ST_WRAP:    cmd.wrap       = 1'b1;
      ST_SPREAD:  cmd.spread     = 1'b1;
      ST_MEAN_LD: cmd.mean_ld    = 1'b1;
      ST_DONE:    cmd.res_load   = !st.res_busy;
      default:    cmd = '0;
    endcase
  end

endmodule

@@ sv/wind_direction_circular_mean.sv @@
// Top level of the wind direction circular mean block.
// Joins wdcm_ctrl and wdcm_datapath; depends on wdcm_pkg and wdcm_if.
//
//   channel     dir  handshake      payload
//   sample_in   in   valid/ready    angle_tenths[11:0], sample_ok
//   result_out  out  valid/ready    mean_deg[8:0], spread_deg[8:0], samples_held[9:0]
//   cfg         in   cfg_we         cfg_wdata[9:0] (window_samples)
//
// A failed read needs one CORDIC vectoring run for the mean. A pushed sample
// needs three 16-step CORDIC runs and the merge pass over the sorted-angle
// RAM, which reads each entry in a wait state and a merge step. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is accepted. Reset is synchronous and clears the store at
// once; a full result register stalls only the last step.
module wind_direction_circular_mean import wdcm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata,
  wdcm_in_if.sink          sample_in,
  wdcm_out_if.source       result_out
);

  cmd_t    cmd;
  status_t st;

  wdcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (sample_in.ready),
    .st       (st),
    .cmd      (cmd)
  );

  wdcm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_angle   (sample_in.angle_tenths),
    .in_ok      (sample_in.sample_ok),
    .out_ready  (result_out.ready),
    .out_valid  (result_out.valid),
    .out_mean   (result_out.mean_deg),
    .out_spread (result_out.spread_deg),
    .out_held   (result_out.samples_held)
  );

endmodule
